// ===== design/b2d_pkg.sv =====
// Shared constants, types and helpers of the binary to decimal ASCII unit.
package b2d_pkg;

  // Width of the binary value that is converted.
  localparam int unsigned VALUE_BITS = 64;

  // Decimal digits that the largest value needs: ceil(VALUE_BITS * log10(2)).
  localparam int unsigned NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_BITS   = 4 * NUM_DIGITS;

  // Counter widths for the bit loop and the digit loop.
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CHAR_W     = 6;

  // ASCII code of the character '0'.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  // Double dabble correction of one BCD digit.
  function automatic logic [3:0] add3(input logic [3:0] digit);
    logic [3:0] res;
    res = (digit >= 4'd5) ? 4'(digit + 4'd3) : digit;
    return res;
  endfunction

endpackage

// ===== design/b2d_dabble.sv =====
// Bit-serial double dabble: shifts a binary value into a BCD register, one bit per cycle.
module b2d_dabble import b2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic [BCD_BITS-1:0]   bcd_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [BCD_BITS-1:0]   corr;
  logic [BIT_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // Correct every digit that is five or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      corr[4*i +: 4] = add3(bcd_q[4*i +: 4]);
    end
  end

  // Load on start, otherwise shift one bit per cycle while busy.
  always_comb begin
    val_d  = val_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      bcd_d  = '0;
      cnt_d  = BIT_CNT_W'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {corr[BCD_BITS-2:0], val_q[VALUE_BITS-1]};
      val_d = {val_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - BIT_CNT_W'(1);
      if (cnt_q == BIT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== design/binary_to_decimal_ascii_unit.sv =====
// Top level of the binary to decimal ASCII unit: stream ports, digit emitter.
//
// The slave channel takes one unsigned 64-bit value per transaction on
// s_axis_tdata_i. The master channel returns its decimal text, most
// significant digit first, one ASCII character per transaction in
// m_axis_tdata_o; m_axis_tlast_o marks the least significant digit.
// Leading zeros are dropped; zero gives the single character '0'.
// One value is handled at a time: s_axis_tready_o is high only when idle.
// After acceptance the bit-serial double dabble converts the value,
// then leading zero digits are shifted out at one per cycle (up to 19
// of them), then digits leave at one per cycle while the sink is ready.
// Skipped and emitted digits always add up to twenty, so without stalls
// every item takes equally long whatever its length, set by the 64-bit
// serial shift loop and the twenty-digit output shifter. The next value
// is taken only after the last digit has left.
// If the sink stalls, the current digit holds on m_axis_tdata_o and the
// unit waits; nothing is lost. Reset returns the unit to idle and drops
// any item in progress.
module binary_to_decimal_ascii_unit import b2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [63:0] value
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [5:0] ascii_digit, [7:6] zero
  output logic                  m_axis_tlast_o
);

  state_e                state_q, state_d;
  logic [BCD_BITS-1:0]   dig_q, dig_d;
  logic [DIG_CNT_W-1:0]  rem_q, rem_d;
  logic                  start;
  logic                  conv_done;
  logic [BCD_BITS-1:0]   conv_bcd;
  logic [3:0]            top_digit;
  logic                  in_acc;
  logic                  out_acc;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc   = m_axis_tvalid_o && m_axis_tready_i;
  assign start     = in_acc;
  assign top_digit = dig_q[BCD_BITS-1 -: 4];

  // Serial converter.
  b2d_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (s_axis_tdata_i[VALUE_BITS-1:0]),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // Next state: wait for conversion, skip leading zeros, emit digits.
  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          rem_d   = DIG_CNT_W'(NUM_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem_q != DIG_CNT_W'(1)) begin
          dig_d = {dig_q[BCD_BITS-5:0], 4'd0};
          rem_d = rem_q - DIG_CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (rem_q == DIG_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            dig_d = {dig_q[BCD_BITS-5:0], 4'd0};
            rem_d = rem_q - DIG_CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

  // Digit shift register.
  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  // Stream outputs are decoded from the state and digit registers.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_EMIT);
  assign m_axis_tdata_o  = {2'b00, CHAR_W'(ASCII_ZERO + {2'b00, top_digit})};
  assign m_axis_tlast_o  = (rem_q == DIG_CNT_W'(1));

endmodule

// ===== design/b2d_checker.sv =====
// Port-level assertions for the binary to decimal ASCII unit, bound to the top level.
module b2d_checker import b2d_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  // Only one item is in flight: no intake while digits are offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while output valid");

  // An accepted value closes the slave channel on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after a transaction");

  // Every offered character is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o >= 8'd48 && m_axis_tdata_o <= 8'd57))
    else $error("output character is not a decimal digit");

  // The last digit ends the run and the unit returns to idle.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o)
      |=> (!m_axis_tvalid_o && s_axis_tready_o))
    else $error("run did not end after the last digit");

  // A stalled digit holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
      |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output changed");

endmodule

bind binary_to_decimal_ascii_unit b2d_checker u_b2d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== sim/binary_to_decimal_ascii_unit_test.sv =====
// Self-checking testbench of the binary to decimal ASCII unit.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_test;
  import b2d_pkg::*;

  // One expected digit transaction on the master channel.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_t;

  localparam int NUM_DIRECTED     = 20;
  localparam int RANDOM_PER_PHASE = 144;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 120;
  localparam int STALL_LIMIT      = 3000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;   // [63:0] value
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;   // [5:0] ascii_digit, [7:6] zero
  logic                  m_axis_tlast_o;

  // Digits still owed by the unit, oldest first.
  digit_t pending_digits [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit hold_request  = 1'b0;
  int sink_hold_left = 0;
  int idle_cycles   = 0;
  int errors        = 0;
  int values_sent   = 0;
  int digits_seen   = 0;
  int full_runs     = 0;

  // Directed values. The text is typed in where it is plain to read;
  // an empty entry means the digit predictor supplies the expectation.
  bit [63:0] dir_value [NUM_DIRECTED] = '{
    64'd0, 64'd1, 64'd8, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
    64'd1234567890, 64'd1000000, 64'hFFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'd9999999999999999999, 64'd10000000000000000000,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'h0123_4567_89AB_CDEF, 64'd0
  };
  string dir_text [NUM_DIRECTED] = '{
    "0", "1", "8", "9", "10", "99", "100", "",
    "1234567890", "", "",
    "18446744073709551615", "9223372036854775808", "9223372036854775807",
    "9999999999999999999", "10000000000000000000",
    "", "",
    "", "0"
  };

  binary_to_decimal_ascii_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decimal expansion of one value, queued most significant digit first.
  // Returns the number of digits queued.
  function automatic int predict_digits(input bit [63:0] val);
    bit [63:0] mask;
    bit [63:0] rest;
    bit [3:0]  rev [20];
    int        n;
    mask = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
    rest = val & mask;
    n = 0;
    do begin
      rev[n] = 4'(rest % 64'd10);
      rest   = rest / 64'd10;
      n++;
    end while (rest != 64'd0);
    for (int k = n - 1; k >= 0; k--) begin
      pending_digits.push_back('{code: ASCII_ZERO + CHAR_W'(rev[k]), last: (k == 0)});
    end
    return n;
  endfunction

  // Queue a digit string typed in by hand.
  function automatic int queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      pending_digits.push_back('{code: CHAR_W'(txt[i]), last: (i == txt.len() - 1)});
    end
    return txt.len();
  endfunction

  // Random value that spreads over all digit counts and digit boundaries.
  function automatic bit [63:0] random_value();
    bit [63:0] v;
    bit [63:0] p10;
    int        k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        k = $urandom_range(1, 64);
        if (k < 64) v = v & ((64'd1 << k) - 64'd1);
      end
      2: begin
        p10 = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p10 = p10 * 64'd10;
        v = p10 - 64'($urandom_range(0, 1));
      end
      default: begin
        v = 64'($urandom_range(0, 999));
      end
    endcase
    return v;
  endfunction

  // Offer one value and wait for its transaction; queue its expected digits.
  task automatic send_value(input bit [63:0] val, input string txt);
    int n;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n = (txt.len() != 0) ? queue_text(txt) : predict_digits(val);
    values_sent++;
    if (n == 20) full_runs++;
  endtask

  // Compare one digit transaction with the oldest expectation.
  task automatic check_digit();
    digit_t want;
    digits_seen++;
    if (pending_digits.size() == 0) begin
      $display("%0t: unexpected digit, actual data %h last %b",
               $time, m_axis_tdata_o, m_axis_tlast_o);
      errors++;
    end else begin
      want = pending_digits.pop_front();
      if (m_axis_tdata_o !== {2'b00, want.code}) begin
        $display("%0t: digit mismatch, expected %h actual %h",
                 $time, {2'b00, want.code}, m_axis_tdata_o);
        errors++;
      end
      if (m_axis_tlast_o !== want.last) begin
        $display("%0t: last flag mismatch, expected %b actual %b",
                 $time, want.last, m_axis_tlast_o);
        errors++;
      end
    end
  endtask

  // Sink side: check accepted digits, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o && m_axis_tready_i) check_digit();
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request   = 1'b0;
      sink_hold_left = SINK_HOLD_CYCLES - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: slow sink, sender mostly busy.
    src_idle_pct  = 16;
    sink_idle_pct = 65;
    for (int i = 0; i < NUM_DIRECTED; i++) send_value(dir_value[i], dir_text[i]);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_value(random_value(), "");

    // Phase two: slow sender, sink mostly ready; pause once until drained.
    src_idle_pct  = 65;
    sink_idle_pct = 16;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == RANDOM_PER_PHASE / 2) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_digits.size() != 0) @(posedge clk_i);
      end
      send_value(random_value(), "");
    end

    // Phase three: no idling, with one long sink hold-off at the start.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_request  = 1'b1;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) send_value(random_value(), "");
    s_axis_tvalid_i <= 1'b0;

    // Let every digit arrive, then watch for stray ones.
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_digits.size() != 0) begin
      $display("%0t: %0d digits never arrived", $time, pending_digits.size());
      errors++;
    end

    $display("Converted %0d values (%0d of twenty digits), checked %0d digit transactions,",
             values_sent, full_runs, digits_seen);
    $display("under three idle profiles with one long sink stall; %0d errors.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/b2d_pkg.sv
design/b2d_dabble.sv
design/binary_to_decimal_ascii_unit.sv
design/b2d_checker.sv
sim/binary_to_decimal_ascii_unit_test.sv
